### hdl/sfd_pkg.sv
// Shared types and constants for the sequenced frame deframer.
// No dependencies; imported by every module in hdl/.
package sfd_pkg;

    // Frame format
    localparam int ID_DIGITS  = 3;
    localparam int LEN_DIGITS = 4;
    localparam int MAX_MARKER = 4;
    localparam int MAX_ID     = 999;
    localparam int HALF_ID    = MAX_ID / 2;

    // Field widths
    localparam int ID_W    = 10;
    localparam int LEN_W   = 14;
    localparam int CNT_W   = 14;
    localparam int KIND_W  = 2;
    localparam int DCNT_W  = 3;
    localparam int HOLD_N  = MAX_MARKER - 1;
    localparam int HCNT_W  = $clog2(MAX_MARKER);
    localparam int MLEN_W  = 3;

    // Stream widths
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPORT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    // Register indexes
    localparam logic REG_MARKER_LEN   = 1'b0;
    localparam logic REG_MARKER_BYTES = 1'b1;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        PH_ID,
        PH_LEN,
        PH_PAY
    } t_phase;

    // One queue entry: all results caused by one input word
    typedef struct packed {
        logic [MLEN_W-1:0]                rel_cnt;
        logic [MAX_MARKER-1:0][7:0]       bytes;
        logic                             report;
        logic                             error;
        logic [ID_W-1:0]                  frame_id;
        logic [LEN_W-1:0]                 length;
        logic                             skip;
    } t_cmd;

endpackage

### hdl/sequenced_frame_deframer.sv
// Top level of the sequenced frame deframer: config registers, front, queue, back.
// Depends on sfd_pkg, sfd_front, sfd_queue, sfd_back.
//
//  channel   | dir | handshake                      | contents
//  s_axis    | in  | s_axis_tvalid / s_axis_tready   | one stream byte + consumer id
//  m_axis    | out | m_axis_tvalid / m_axis_tready   | payload byte, frame report or error
//  apb       | in  | psel & penable & pwrite         | marker_length (0x0), marker_bytes (0x4)
//
// One input word per cycle. A byte yields 0..4 results; the back end sends one per
// cycle unless m_axis stalls, so the 4-entry queue absorbs bursts and s_axis_tready
// drops only when it is full. Reset is synchronous; no clearing pass, ready right after.
// The output is registered: a stalled m_axis keeps accepting until the queue fills.
module sequenced_frame_deframer
    import sfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_DATA_W-1:0]   s_axis_tdata,   // [7:0] in_byte, [17:8] current_id
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_DATA_W-1:0]   m_axis_tdata,   // [7:0] data_byte, [17:8] frame_id,
                                                  // [31:18] declared_length, [32] skip
    output logic [KIND_W-1:0]     m_axis_tuser,   // [1:0] kind
    output logic                  m_axis_tlast,
    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [MLEN_W-1:0]  r_marker_len;
    logic [31:0]        r_marker_bytes;
    logic               wr_en;

    logic               push;
    t_cmd               cmd;
    logic               pop;
    logic               full;
    logic               empty;
    t_cmd               head;
    logic               s_accept;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker_len   <= MLEN_W'(1);
            r_marker_bytes <= '0;
        end else if (wr_en) begin
            case (paddr[2])
                REG_MARKER_LEN:   r_marker_len   <= pwdata[MLEN_W-1:0];
                REG_MARKER_BYTES: r_marker_bytes <= pwdata;
                default:          r_marker_len   <= r_marker_len;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[2])
            REG_MARKER_LEN:   prdata = {{(32-MLEN_W){1'b0}}, r_marker_len};
            REG_MARKER_BYTES: prdata = r_marker_bytes;
            default:          prdata = '0;
        endcase
    end

    assign s_axis_tready = !full;
    assign s_accept      = s_axis_tvalid && !full;

    sfd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_accept),
        .i_byte         (s_axis_tdata[7:0]),
        .i_current_id   (s_axis_tdata[17:8]),
        .i_marker_len   (r_marker_len),
        .i_marker_bytes (r_marker_bytes),
        .o_push         (push),
        .o_cmd          (cmd)
    );

    sfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    sfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_kind  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

endmodule

### hdl/sfd_front.sv
// Front end: header digit parsing, marker search and payload counting.
// Depends on sfd_pkg; pushes one t_cmd per result-producing byte.
module sfd_front
    import sfd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_byte,
    input  logic [ID_W-1:0]        i_current_id,
    input  logic [MLEN_W-1:0]      i_marker_len,
    input  logic [31:0]            i_marker_bytes,
    output logic                   o_push,
    output t_cmd                   o_cmd
);

    t_phase                    r_phase, n_phase;
    logic [DCNT_W-1:0]         r_dcnt, n_dcnt;
    logic [ID_W-1:0]           r_id, n_id;
    logic [LEN_W-1:0]          r_len, n_len;
    logic [CNT_W-1:0]          r_pay, n_pay;
    logic [HCNT_W-1:0]         r_hcnt, n_hcnt;
    logic [HOLD_N-1:0][7:0]    r_held, n_held;

    logic [MAX_MARKER-1:0][7:0] cand;
    logic [MLEN_W-1:0]          mlen;
    logic [MLEN_W-1:0]          ncand;
    logic [MLEN_W-1:0]          k;
    logic [MLEN_W-1:0]          rel;
    logic                       ok;
    logic                       is_digit;
    logic [3:0]                 dval;
    logic [CNT_W:0]             cnt_sum;
    logic [CNT_W-1:0]           cnt_new;
    logic [ID_W:0]              diff;
    logic [ID_W:0]              adiff;
    logic                       old_id;

    // Clamp marker length to 1..MAX_MARKER
    always_comb begin
        if (i_marker_len == '0) begin
            mlen = MLEN_W'(1);
        end else if (i_marker_len > MLEN_W'(MAX_MARKER)) begin
            mlen = MLEN_W'(MAX_MARKER);
        end else begin
            mlen = i_marker_len;
        end
    end

    // Candidate: held bytes followed by the new byte
    always_comb begin
        for (int j = 0; j < MAX_MARKER; j++) begin
            if (j < HOLD_N && HCNT_W'(j) < r_hcnt) begin
                cand[j] = r_held[(j < HOLD_N) ? j : 0];
            end else begin
                cand[j] = i_byte;
            end
        end
        ncand = MLEN_W'(r_hcnt) + MLEN_W'(1);
    end

    // Longest tail of the candidate that is a marker prefix
    always_comb begin
        k = '0;
        for (int kk = 1; kk <= MAX_MARKER; kk++) begin
            ok = (MLEN_W'(kk) <= ncand) && (MLEN_W'(kk) <= mlen);
            for (int i = 0; i < kk; i++) begin
                if (cand[HCNT_W'(int'(ncand) - kk + i)] != i_marker_bytes[8*i +: 8]) begin
                    ok = 1'b0;
                end
            end
            if (ok) begin
                k = MLEN_W'(kk);
            end
        end
        rel = ncand - k;
    end

    // Saturating payload count after this byte's releases
    always_comb begin
        cnt_sum = {1'b0, r_pay} + (CNT_W+1)'(rel);
        cnt_new = cnt_sum[CNT_W] ? COUNT_MAX : cnt_sum[CNT_W-1:0];
    end

    // Wrap-aware duplicate rule
    always_comb begin
        diff   = {1'b0, i_current_id} - {1'b0, r_id};
        adiff  = diff[ID_W] ? (~diff + (ID_W+1)'(1)) : diff;
        if (adiff < (ID_W+1)'(HALF_ID)) begin
            old_id = (r_id <= i_current_id);
        end else begin
            old_id = (r_id > ID_W'(HALF_ID));
        end
    end

    assign is_digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign dval     = 4'(i_byte - 8'h30);

    // Next state and queue entry
    always_comb begin
        n_phase = r_phase;
        n_dcnt  = r_dcnt;
        n_id    = r_id;
        n_len   = r_len;
        n_pay   = r_pay;
        n_hcnt  = r_hcnt;
        n_held  = r_held;
        o_push  = 1'b0;

        o_cmd          = '0;
        o_cmd.bytes    = cand;
        o_cmd.frame_id = r_id;
        o_cmd.length   = r_len;

        if (i_valid) begin
            case (r_phase)
                PH_ID, PH_LEN: begin
                    if (!is_digit) begin
                        o_push      = 1'b1;
                        o_cmd.error = 1'b1;
                        n_phase     = PH_ID;
                        n_dcnt      = '0;
                        n_id        = '0;
                        n_len       = '0;
                        n_pay       = '0;
                        n_hcnt      = '0;
                    end else if (r_phase == PH_LEN) begin
                        n_len  = LEN_W'(r_len * LEN_W'(10) + LEN_W'(dval));
                        n_dcnt = r_dcnt + DCNT_W'(1);
                        if (n_dcnt >= DCNT_W'(LEN_DIGITS)) begin
                            n_phase = PH_PAY;
                            n_dcnt  = '0;
                            n_pay   = '0;
                            n_hcnt  = '0;
                        end
                    end else begin
                        n_id   = ID_W'(r_id * ID_W'(10) + ID_W'(dval));
                        n_dcnt = r_dcnt + DCNT_W'(1);
                        if (n_dcnt >= DCNT_W'(ID_DIGITS)) begin
                            n_phase = PH_LEN;
                            n_dcnt  = '0;
                        end
                    end
                end
                PH_PAY: begin
                    o_cmd.rel_cnt = rel;
                    n_pay         = cnt_new;
                    if (k == mlen) begin
                        o_cmd.report = 1'b1;
                        o_cmd.skip   = old_id || (cnt_new != r_len);
                        o_push       = 1'b1;
                        n_phase      = PH_ID;
                        n_dcnt       = '0;
                        n_id         = '0;
                        n_len        = '0;
                        n_pay        = '0;
                        n_hcnt       = '0;
                    end else begin
                        o_push = (rel != '0);
                        n_hcnt = HCNT_W'(k);
                        for (int i = 0; i < HOLD_N; i++) begin
                            n_held[i] = cand[HCNT_W'(int'(rel) + i)];
                        end
                    end
                end
                default: begin
                    n_phase = PH_ID;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ID;
            r_dcnt  <= '0;
            r_id    <= '0;
            r_len   <= '0;
            r_pay   <= '0;
            r_hcnt  <= '0;
        end else begin
            r_phase <= n_phase;
            r_dcnt  <= n_dcnt;
            r_id    <= n_id;
            r_len   <= n_len;
            r_pay   <= n_pay;
            r_hcnt  <= n_hcnt;
        end
    end

    // Held marker-prefix bytes, no reset needed
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

endmodule

### hdl/sfd_queue.sv
// Short FIFO of t_cmd entries between front and back.
// Depends on sfd_pkg.
module sfd_queue
    import sfd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_cmd   o_head
);

    t_cmd                r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [QPTR_W:0]     r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QPTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QPTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

### hdl/sfd_back.sv
// Back end: expands each queued entry into result words, one per cycle unless the output stalls.
// Depends on sfd_pkg; drives the registered master stream.
module sfd_back
    import sfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  t_cmd                  i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [M_DATA_W-1:0]   o_data,
    output logic [KIND_W-1:0]     o_kind,
    output logic                  o_last
);

    logic [HCNT_W-1:0]    r_idx, n_idx;
    logic                 r_valid;
    logic [M_DATA_W-1:0]  r_data;
    logic [KIND_W-1:0]    r_kind;
    logic                 r_last;

    logic                 load;
    logic [MLEN_W-1:0]    total;
    logic                 w_last;
    logic [M_DATA_W-1:0]  w_data;
    logic [KIND_W-1:0]    w_kind;

    assign load  = !i_empty && (!r_valid || i_ready);
    assign total = i_head.rel_cnt + MLEN_W'(i_head.report | i_head.error);

    // Word at the current position of the head entry
    always_comb begin
        w_last = (MLEN_W'(r_idx) + MLEN_W'(1) == total);
        w_data = '0;
        if (MLEN_W'(r_idx) < i_head.rel_cnt) begin
            w_kind      = KIND_PAYLOAD;
            w_data[7:0] = i_head.bytes[r_idx];
        end else if (i_head.error) begin
            w_kind = KIND_ERROR;
        end else begin
            w_kind         = KIND_REPORT;
            w_data[17:8]   = i_head.frame_id;
            w_data[31:18]  = i_head.length;
            w_data[32]     = i_head.skip;
        end
        o_pop = load && w_last;
        n_idx = r_idx;
        if (load) begin
            n_idx = w_last ? '0 : r_idx + HCNT_W'(1);
        end
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= w_data;
            r_kind <= w_kind;
            r_last <= w_last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_kind  = r_kind;
    assign o_last  = r_last;

endmodule
